// ----- rtl/lrupr_pkg.sv -----
package lrupr_pkg;

   localparam int MAX_FRAME_DEPTH = 16;
   localparam int PAGE_WIDTH      = 10;

   // index into the recency list and a count that can hold the depth itself
   localparam int IDX_WIDTH = (MAX_FRAME_DEPTH > 1) ? $clog2(MAX_FRAME_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(MAX_FRAME_DEPTH + 1);

   localparam int FRAME_CFG_WIDTH = 5;
   localparam int TOTAL_WIDTH     = 32;

   typedef logic [IDX_WIDTH-1:0]   idx_type;
   typedef logic [CNT_WIDTH-1:0]   cnt_type;
   typedef logic [PAGE_WIDTH-1:0]  page_type;
   typedef logic [TOTAL_WIDTH-1:0] total_type;

   // one slot of the recency list
   typedef struct packed {
      logic     dirty;
      page_type page;
   } entry_type;

   typedef struct packed {
      logic     dirty;
      page_type page;
   } req_type;

   typedef struct packed {
      logic      hit;
      logic      evicted;
      logic      write_back;
      page_type  evicted_page;
      total_type fault_total;
      total_type writeback_total;
   } res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SH_RD,
      ST_SH_WR,
      ST_FRONT
   } state_type;

endpackage

// ----- rtl/lrupr_frame_ram.sv -----
module lrupr_frame_ram
   import lrupr_pkg::*;
(
   input  logic      clock,
   input  idx_type   rd_addr,
   output entry_type rd_data,
   input  logic      wr_en,
   input  idx_type   wr_addr,
   input  entry_type wr_data
);

   entry_type mem [MAX_FRAME_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lrupr_seq.sv -----
module lrupr_seq
   import lrupr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req,
   input  cnt_type   eff_frames,
   input  logic      out_free,
   output logic      res_valid,
   output res_type   res,
   output idx_type   rd_addr,
   input  entry_type rd_data,
   output logic      wr_en,
   output idx_type   wr_addr,
   output entry_type wr_data
);

   state_type state_ff, state_in;
   page_type  page_ff, page_in;
   logic      dirty_ff, dirty_in;
   cnt_type   rd_idx_ff, rd_idx_in;
   logic      cmp_vld_ff, cmp_vld_in;
   idx_type   cmp_idx_ff, cmp_idx_in;
   idx_type   sh_idx_ff, sh_idx_in;
   logic      hit_ff, hit_in;
   logic      evict_ff, evict_in;
   page_type  ev_page_ff, ev_page_in;
   logic      wb_ff, wb_in;
   logic      grow_ff, grow_in;
   cnt_type   used_ff, used_in;
   total_type faults_ff, faults_in;
   total_type wbs_ff, wbs_in;
   logic      decided;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         used_ff    <= '0;
         faults_ff  <= '0;
         wbs_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         used_ff    <= used_in;
         faults_ff  <= faults_in;
         wbs_ff     <= wbs_in;
      end
      page_ff    <= page_in;
      dirty_ff   <= dirty_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      sh_idx_ff  <= sh_idx_in;
      hit_ff     <= hit_in;
      evict_ff   <= evict_in;
      ev_page_ff <= ev_page_in;
      wb_ff      <= wb_in;
      grow_ff    <= grow_in;
   end

   always_comb begin
      state_in   = state_ff;
      page_in    = page_ff;
      dirty_in   = dirty_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      sh_idx_in  = sh_idx_ff;
      hit_in     = hit_ff;
      evict_in   = evict_ff;
      ev_page_in = ev_page_ff;
      wb_in      = wb_ff;
      grow_in    = grow_ff;
      used_in    = used_ff;
      faults_in  = faults_ff;
      wbs_in     = wbs_ff;
      decided    = 1'b0;
      req_ready  = 1'b0;
      res_valid  = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               page_in    = req.page;
               dirty_in   = req.dirty;
               hit_in     = 1'b0;
               evict_in   = 1'b0;
               ev_page_in = '0;
               wb_in      = 1'b0;
               grow_in    = 1'b0;
               rd_idx_in  = '0;
               sh_idx_in  = '0;
               if (used_ff == '0) begin
                  // empty list: straight into slot zero
                  grow_in  = 1'b1;
                  state_in = ST_FRONT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (cmp_vld_ff) begin
               if (rd_data.page == page_ff) begin
                  decided   = 1'b1;
                  hit_in    = 1'b1;
                  dirty_in  = rd_data.dirty | dirty_ff;
                  sh_idx_in = cmp_idx_ff;
                  state_in  = (cmp_idx_ff == '0) ? ST_FRONT : ST_SH_RD;
               end else if (CNT_WIDTH'(cmp_idx_ff) == used_ff - CNT_WIDTH'(1)) begin
                  decided = 1'b1;
                  if (used_ff < eff_frames) begin
                     grow_in   = 1'b1;
                     sh_idx_in = IDX_WIDTH'(used_ff);
                     state_in  = ST_SH_RD;
                  end else begin
                     // list full: the tail just read is the victim
                     evict_in   = 1'b1;
                     ev_page_in = rd_data.page;
                     wb_in      = rd_data.dirty;
                     sh_idx_in  = cmp_idx_ff;
                     state_in   = (cmp_idx_ff == '0) ? ST_FRONT : ST_SH_RD;
                  end
               end
            end
            if (!decided && (rd_idx_ff < used_ff)) begin
               rd_addr    = IDX_WIDTH'(rd_idx_ff);
               cmp_vld_in = 1'b1;
               cmp_idx_in = IDX_WIDTH'(rd_idx_ff);
               rd_idx_in  = rd_idx_ff + CNT_WIDTH'(1);
            end
         end

         ST_SH_RD: begin
            rd_addr  = sh_idx_ff - IDX_WIDTH'(1);
            state_in = ST_SH_WR;
         end

         ST_SH_WR: begin
            // move slot sh_idx-1 into sh_idx, next read two below
            wr_en   = 1'b1;
            wr_addr = sh_idx_ff;
            wr_data = rd_data;
            if (sh_idx_ff == IDX_WIDTH'(1)) begin
               state_in = ST_FRONT;
            end else begin
               rd_addr   = sh_idx_ff - IDX_WIDTH'(2);
               sh_idx_in = sh_idx_ff - IDX_WIDTH'(1);
            end
         end

         ST_FRONT: begin
            if (out_free) begin
               wr_en         = 1'b1;
               wr_addr       = '0;
               wr_data.dirty = dirty_ff;
               wr_data.page  = page_ff;
               if (!hit_ff && (faults_ff != '1)) begin
                  faults_in = faults_ff + TOTAL_WIDTH'(1);
               end
               if (wb_ff && (wbs_ff != '1)) begin
                  wbs_in = wbs_ff + TOTAL_WIDTH'(1);
               end
               if (grow_ff) begin
                  used_in = used_ff + CNT_WIDTH'(1);
               end
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.hit             = hit_ff;
      res.evicted         = evict_ff;
      res.write_back      = wb_ff;
      res.evicted_page    = ev_page_ff;
      res.fault_total     = faults_in;
      res.writeback_total = wbs_in;
   end

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_WIDTH'(MAX_FRAME_DEPTH))
      else $error("frame occupancy beyond built depth");

   a_shift_not_front: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SH_WR) |-> (sh_idx_ff != '0))
      else $error("shift writing slot zero");

   a_cmp_only_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == ST_SCAN))
      else $error("compare pending outside scan");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(res.hit && (res.evicted || res.write_back)))
      else $error("hit reported with eviction");

endmodule

// ----- rtl/lru_page_replacement_dirty.sv -----
// LRU page replacement with dirty tracking. Each req item carries a page
// number and a dirty mark; each rsp item reports hit, eviction, the evicted
// page, whether it needs a write-back, and the running fault and write-back
// totals (both saturate at all ones). The recency list (slot 0 most recent)
// sits in a single-port-read synchronous RAM. One read port walks the list
// to find the page, then the same port walks it again to shift entries one
// slot down before the new front entry is written. No shift is needed for
// a hit at slot 0, for an eviction from a single occupied frame or for an
// empty list, which goes straight to the front write. One item is worked
// on at a time; a new item is taken while the previous result still waits
// in the rsp register. frame_count is written through csr_wr_en /
// csr_wr_data; the user must write it only while idle, and the block itself
// does not enforce this. 0 acts as 1 and values above the built depth act
// as the depth.
module lru_page_replacement_dirty
   import lrupr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // config write port
   input  logic                       csr_wr_en,
   input  logic [FRAME_CFG_WIDTH-1:0] csr_wr_data,   // frame_count
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,     // page_num[9:0], zero pad
   input  logic                       req_tuser,     // ref_dirty
   // response channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [79:0]                rsp_tdata,     // evicted_page[9:0],
                                                     // fault_total[41:10],
                                                     // writeback_total[73:42], zero pad
   output logic [2:0]                 rsp_tuser      // hit, evicted, write_back
);

   logic [FRAME_CFG_WIDTH-1:0] frame_count_ff;
   cnt_type                    eff_frames;

   logic      rsp_valid_ff, rsp_valid_in;
   res_type   rsp_ff;
   logic      out_free;

   req_type   req;
   logic      res_valid;
   res_type   res;

   idx_type   rd_addr;
   entry_type rd_data;
   logic      wr_en;
   idx_type   wr_addr;
   entry_type wr_data;

   // frame count register, reset to the full built depth
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_CFG_WIDTH'(16);
      end else if (csr_wr_en) begin
         frame_count_ff <= csr_wr_data;
      end
   end

   // clamp the configured count to 1..built depth
   always_comb begin
      priority if (frame_count_ff == '0) begin
         eff_frames = CNT_WIDTH'(1);
      end else if (32'(frame_count_ff) > MAX_FRAME_DEPTH) begin
         eff_frames = CNT_WIDTH'(MAX_FRAME_DEPTH);
      end else begin
         eff_frames = CNT_WIDTH'(frame_count_ff);
      end
   end

   // only the low page bits are significant
   assign req.page  = PAGE_WIDTH'(req_tdata[9:0]);
   assign req.dirty = req_tuser;

   // rsp output register, refilled as it drains
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.write_back, rsp_ff.evicted, rsp_ff.hit};
   assign rsp_tdata  = {6'b0, rsp_ff.writeback_total, rsp_ff.fault_total,
                        10'(rsp_ff.evicted_page)};

   lrupr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .eff_frames (eff_frames),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   // recency list storage
   lrupr_frame_ram u_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

// ----- test/lru_page_checker.sv -----
module lru_page_checker
   import lrupr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [FRAME_CFG_WIDTH-1:0] csr_wr_data,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [15:0]                req_tdata,     // page_num[9:0], zero pad
   input  logic                       req_tuser,     // ref_dirty
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [79:0]                rsp_tdata,     // evicted_page[9:0],
                                                     // fault_total[41:10],
                                                     // writeback_total[73:42], zero pad
   input  logic [2:0]                 rsp_tuser,     // hit, evicted, write_back
   output int                         mismatches,
   output int                         outstanding,
   output int                         results_checked,
   output int                         hits_seen,
   output int                         evictions_seen,
   output int                         write_backs_seen
);

   logic [FRAME_CFG_WIDTH-1:0] frame_setting;
   page_type                   lru_page [MAX_FRAME_DEPTH];
   logic                       lru_dirty [MAX_FRAME_DEPTH];
   int                         occupied;
   total_type                  fault_count;
   total_type                  writeback_count;
   res_type                    pending_outcomes [$];
   res_type                    observed;
   res_type                    predicted;
   int                         slot;

   initial begin
      mismatches       = 0;
      outstanding      = 0;
      results_checked  = 0;
      hits_seen        = 0;
      evictions_seen   = 0;
      write_backs_seen = 0;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] result %0d: %s", $time, results_checked, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   // slide slots 0..last-1 one place toward the tail, new page goes in front
   function automatic void shift_in(int last, page_type page, logic dirty);
      int i;
      for (i = last; i > 0; i--) begin
         lru_page[i]  = lru_page[i-1];
         lru_dirty[i] = lru_dirty[i-1];
      end
      lru_page[0]  = page;
      lru_dirty[0] = dirty;
   endfunction

   function automatic res_type touch_page(page_type page, logic dirty);
      res_type r;
      int      pos;
      int      limit;
      int      i;
      r   = '0;
      pos = -1;
      if (int'(frame_setting) == 0) begin
         limit = 1;
      end else if (int'(frame_setting) > MAX_FRAME_DEPTH) begin
         limit = MAX_FRAME_DEPTH;
      end else begin
         limit = int'(frame_setting);
      end
      for (i = 0; i < occupied; i++) begin
         if (pos < 0 && lru_page[i] == page) begin
            pos = i;
         end
      end
      if (pos >= 0) begin
         r.hit = 1'b1;
         shift_in(pos, page, lru_dirty[pos] | dirty);
      end else begin
         if (fault_count != '1) begin
            fault_count = fault_count + 1;
         end
         if (occupied < limit) begin
            shift_in(occupied, page, dirty);
            occupied++;
         end else begin
            // frames stay occupied even after the count was lowered
            r.evicted      = 1'b1;
            r.evicted_page = lru_page[occupied-1];
            if (lru_dirty[occupied-1]) begin
               r.write_back = 1'b1;
               if (writeback_count != '1) begin
                  writeback_count = writeback_count + 1;
               end
            end
            shift_in(occupied - 1, page, dirty);
         end
      end
      r.fault_total     = fault_count;
      r.writeback_total = writeback_count;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         frame_setting   = FRAME_CFG_WIDTH'(MAX_FRAME_DEPTH);
         occupied        = 0;
         fault_count     = '0;
         writeback_count = '0;
         for (slot = 0; slot < MAX_FRAME_DEPTH; slot++) begin
            lru_page[slot]  = '0;
            lru_dirty[slot] = 1'b0;
         end
         pending_outcomes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            observed.hit             = rsp_tuser[0];
            observed.evicted         = rsp_tuser[1];
            observed.write_back      = rsp_tuser[2];
            observed.evicted_page    = rsp_tdata[9:0];
            observed.fault_total     = rsp_tdata[41:10];
            observed.writeback_total = rsp_tdata[73:42];
            if (pending_outcomes.size() == 0) begin
               report_mismatch("result with no reference outstanding");
            end else begin
               predicted = pending_outcomes.pop_front();
               check_field("hit", 32'(observed.hit), 32'(predicted.hit));
               check_field("evicted", 32'(observed.evicted), 32'(predicted.evicted));
               check_field("evicted_page", 32'(observed.evicted_page),
                           32'(predicted.evicted_page));
               check_field("write_back", 32'(observed.write_back),
                           32'(predicted.write_back));
               check_field("fault_total", observed.fault_total, predicted.fault_total);
               check_field("writeback_total", observed.writeback_total,
                           predicted.writeback_total);
               hits_seen        += int'(predicted.hit);
               evictions_seen   += int'(predicted.evicted);
               write_backs_seen += int'(predicted.write_back);
            end
            results_checked++;
         end
         if (csr_wr_en) begin
            frame_setting = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            pending_outcomes.push_back(touch_page(req_tdata[PAGE_WIDTH-1:0], req_tuser));
         end
      end
      outstanding = pending_outcomes.size();
   end

endmodule

// ----- test/tb.sv -----
module tb;
   import lrupr_pkg::*;

   // no accepted item on either channel for this long means the block hung
   localparam int IDLE_LIMIT    = 500;
   localparam int PHASE_REFS    = 184;
   // extra wait at the end to cover anything still in flight
   localparam int SETTLE_CYCLES = 40;
   localparam int HOT_MAX       = 20;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [FRAME_CFG_WIDTH-1:0] csr_wr_data;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [15:0]                req_tdata;     // page_num[9:0], zero pad
   logic                       req_tuser;     // ref_dirty
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [79:0]                rsp_tdata;     // evicted_page[9:0], fault_total[41:10],
                                              // writeback_total[73:42], zero pad
   logic [2:0]                 rsp_tuser;     // hit, evicted, write_back

   int mismatches;
   int outstanding;
   int results_checked;
   int hits_seen;
   int evictions_seen;
   int write_backs_seen;

   // calm modes switch off the random gaps for a stretch of items
   logic     tx_calm;
   logic     rx_calm;
   int       idle_cycles;
   int       rx_stall;
   page_type hot_pages [HOT_MAX];
   int       hot_size;
   int       phase_frames [10];
   int       phase;
   int       n;
   int       k;
   int       frames;
   int       usable;
   int       pick;
   page_type page;

   lru_page_replacement_dirty dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   lru_page_checker page_check (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .results_checked  (results_checked),
      .hits_seen        (hits_seen),
      .evictions_seen   (evictions_seen),
      .write_backs_seen (write_backs_seen)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // watchdog on accepted items, either channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item accepted for %0d cycles, %0d results still due",
                  IDLE_LIMIT, outstanding);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stall before each item, tready held while waiting
   initial begin
      rsp_tready = 1'b0;
      rx_calm    = 1'b0;
      forever begin
         rx_stall = rx_calm ? 0 : $urandom_range(0, 19);
         if (rx_stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (rx_stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
         if ($urandom_range(0, 29) == 0) begin
            rx_calm = ~rx_calm;
         end
      end
   end

   // one page reference; returns at the edge where it was accepted
   task automatic send_ref(input page_type pg, input logic dirty);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(16-PAGE_WIDTH){1'b0}}, pg};
      req_tuser  <= dirty;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // hold off the sender until every reference has its result back
   task automatic wait_for_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // only called with the block idle
   task automatic write_frames(input logic [FRAME_CFG_WIDTH-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      tx_calm     = 1'b0;
      // frame settings per random phase, 0 and 31 check the clamping
      phase_frames = '{1, 16, 4, 0, 31, 8, 2, 12, 0, 16};
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: page extremes, a clean hit turning dirty and a dirty hit
      // staying dirty, with the reset frame count of 16
      send_ref(10'd0, 1'b0);
      send_ref(10'd1023, 1'b1);
      send_ref(10'd0, 1'b1);
      send_ref(10'd1023, 1'b0);
      send_ref(10'd341, 1'b1);
      send_ref(10'd682, 1'b0);

      // count lowered to 2 with 4 frames full: old frames still hit,
      // misses evict the oldest and the occupancy stays at 4
      wait_for_quiet();
      write_frames(5'd2);
      send_ref(10'd0, 1'b0);
      send_ref(10'd341, 1'b0);
      send_ref(10'd7, 1'b1);
      send_ref(10'd8, 1'b0);

      // zero acts as one frame
      wait_for_quiet();
      write_frames(5'd0);
      send_ref(10'd9, 1'b1);
      send_ref(10'd9, 1'b0);

      // all ones acts as the full depth, free frames fill again
      wait_for_quiet();
      write_frames(5'd31);
      send_ref(10'd10, 1'b0);
      send_ref(10'd11, 1'b1);
      send_ref(10'd12, 1'b0);

      // random phases: a hot set slightly larger than the frame count keeps
      // hits and evictions both frequent, the rest is spread over all pages
      for (phase = 0; phase < 10; phase++) begin
         frames = phase_frames[phase];
         if (phase == 8) begin
            frames = $urandom_range(1, 16);
         end
         wait_for_quiet();
         write_frames(FRAME_CFG_WIDTH'(frames));
         if (frames == 0) begin
            usable = 1;
         end else if (frames > MAX_FRAME_DEPTH) begin
            usable = MAX_FRAME_DEPTH;
         end else begin
            usable = frames;
         end
         hot_size = usable + $urandom_range(0, 3);
         if (hot_size > HOT_MAX) begin
            hot_size = HOT_MAX;
         end
         for (k = 0; k < hot_size; k++) begin
            hot_pages[k] = page_type'($urandom_range(0, 1023));
         end
         for (n = 0; n < PHASE_REFS; n++) begin
            if ($urandom_range(0, 39) == 0) begin
               tx_calm = ~tx_calm;
            end
            // now and then let the pipe run dry mid-phase
            if ($urandom_range(0, 59) == 0) begin
               wait_for_quiet();
            end
            pick = $urandom_range(0, 19);
            if (pick < 16) begin
               page = hot_pages[$urandom_range(0, hot_size - 1)];
            end else if (pick == 16) begin
               page = ($urandom_range(0, 1) == 0) ? '0 : '1;
            end else begin
               page = page_type'($urandom_range(0, 1023));
            end
            send_ref(page, $urandom_range(0, 2) == 0);
         end
      end

      wait_for_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d references checked: %0d hits, %0d evictions, %0d write-backs",
               results_checked, hits_seen, evictions_seen, write_backs_seen);
      $display("frame counts 0, 1 to 16 and 31 used, including lowering with full frames");
      if (mismatches == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
